/* sv/gltab_pkg.sv */
package gltab_pkg;

  localparam int FUNC_W = 3;
  localparam int SRC_W  = 2;
  localparam int SEQ_W  = 63;
  localparam int PAY_W  = 32;
  localparam int KIN_W  = 8;
  localparam int KEYS_W = 5;
  localparam int TIME_W = 32;
  localparam int CAP_W  = 6;
  localparam int CNT_W  = 32;
  localparam int OUT_W  = 8;
  localparam int USE_W  = 3;

  localparam logic [CAP_W-1:0] CAP_RESET = 6'd32;

  localparam logic [FUNC_W-1:0] FN_APPEND   = 3'd0;
  localparam logic [FUNC_W-1:0] FN_GET      = 3'd1;
  localparam logic [FUNC_W-1:0] FN_TRIM_ONE = 3'd2;
  localparam logic [FUNC_W-1:0] FN_TRIM_ALL = 3'd3;
  localparam logic [FUNC_W-1:0] FN_CLEAR    = 3'd4;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [SRC_W-1:0]  source;
    logic [SEQ_W-1:0]  seq_num;
    logic [PAY_W-1:0]  payload;
    logic [KIN_W-1:0]  key_total;
    logic [TIME_W-1:0] now;
  } item_t;

  typedef struct packed {
    logic [SEQ_W-1:0]  seq_num;
    logic [PAY_W-1:0]  payload;
    logic [KEYS_W-1:0] keys;
    logic [TIME_W-1:0] stamp;
  } slot_t;

  typedef struct packed {
    logic              found;
    logic              evicted;
    logic [OUT_W-1:0]  trimmed;
    slot_t             entry;
    logic [OUT_W-1:0]  total;
    logic [CNT_W-1:0]  hits;
    logic [CNT_W-1:0]  misses;
    logic [USE_W-1:0]  in_use;
  } result_t;

endpackage

/* sv/gltab_ram.sv */
module gltab_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* sv/gltab_seq.sv */
module gltab_seq import gltab_pkg::*; #(
  parameter int SOURCES  = 4,
  parameter int CAPACITY = 32,
  parameter int MAX_KEYS = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [CAP_W-1:0] capacity,
  input  logic             in_valid,
  output logic             in_ready,
  input  item_t            in_item,
  output logic             res_valid,
  input  logic             res_ready,
  output result_t          res
);

  localparam int IW    = $clog2(CAPACITY);
  localparam int FW    = $clog2(CAPACITY + 1);
  localparam int SW    = (SOURCES > 1) ? $clog2(SOURCES) : 1;
  localparam int DEPTH = SOURCES * (1 << IW);
  localparam int AW    = $clog2(DEPTH);
  localparam int TW    = $clog2(SOURCES * CAPACITY + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_GET  = 2'd1;
  localparam logic [1:0] ST_TSEL = 2'd2;
  localparam logic [1:0] ST_TRIM = 2'd3;
  localparam logic [1:0] ST_FIN_UNUSED = 2'd0;

  logic [1:0] state;
  logic       fin;

  logic [IW-1:0]    ring_head   [SOURCES];
  logic [IW-1:0]    ring_tail   [SOURCES];
  logic [FW-1:0]    ring_fill   [SOURCES];
  logic [FW-1:0]    ring_size   [SOURCES];
  logic [SEQ_W-1:0] ring_min    [SOURCES];
  logic [SEQ_W-1:0] ring_max    [SOURCES];
  logic             ring_active [SOURCES];
  logic [TW-1:0]    total;
  logic [CNT_W-1:0] hits;
  logic [CNT_W-1:0] misses;

  logic [SW-1:0]    tr;
  logic [IW-1:0]    ptr;
  logic [FW-1:0]    chk;
  logic             rd_v;
  logic             all_mode;
  logic [SEQ_W-1:0] op_seq;
  logic             found;
  logic             evicted;
  logic [TW-1:0]    trimmed;
  slot_t            ent;

  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  slot_t            ram_wdata;
  logic [AW-1:0]    ram_raddr;
  slot_t            ram_rdata;

  logic [SW-1:0]    s_idx;
  logic             src_ok;
  logic             s_act;
  logic [FW-1:0]    capsat;
  logic [FW-1:0]    a_size;
  logic [IW-1:0]    a_head;
  logic [IW-1:0]    a_tail;
  logic [FW-1:0]    a_fill;
  logic [SEQ_W-1:0] a_min;
  logic [SEQ_W-1:0] a_max;
  logic             a_evict;
  logic [FW-1:0]    a_fill_n;
  logic [SEQ_W-1:0] a_min_n;
  logic [SEQ_W-1:0] a_max_n;
  logic             g_range;
  logic             match;
  logic             take;
  logic [USE_W-1:0] in_use;
  logic [SW-1:0]    last_src;

  function automatic logic [IW-1:0] ptr_inc(input logic [IW-1:0] p, input logic [FW-1:0] sz);
    logic [FW-1:0] q;
    q = FW'(p) + 1'b1;
    return (q == sz) ? '0 : IW'(q);
  endfunction

  function automatic logic [IW-1:0] ptr_dec(input logic [IW-1:0] p, input logic [FW-1:0] sz);
    logic [FW-1:0] q;
    q = sz - 1'b1;
    return (p == '0) ? IW'(q) : p - 1'b1;
  endfunction

  gltab_ram #(
    .WIDTH ($bits(slot_t)),
    .DEPTH (DEPTH)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign last_src = SW'(SOURCES - 1);
  assign in_ready = (state == ST_IDLE) && !fin;
  assign take     = in_valid && in_ready;
  assign s_idx    = SW'(in_item.source);
  assign src_ok   = (int'(in_item.source) < SOURCES);
  assign s_act    = src_ok && ring_active[s_idx];

  always_comb begin
    capsat = ((capacity == '0) || (int'(capacity) > CAPACITY)) ? FW'(CAPACITY) : FW'(capacity);
    a_size = s_act ? ring_size[s_idx] : capsat;
    a_head = s_act ? ring_head[s_idx] : '0;
    a_tail = s_act ? ring_tail[s_idx] : '0;
    a_fill = s_act ? ring_fill[s_idx] : '0;
    a_min  = s_act ? ring_min[s_idx]  : '0;
    a_max  = s_act ? ring_max[s_idx]  : '0;
    a_evict  = (a_fill >= a_size);
    a_fill_n = a_evict ? a_fill : a_fill + 1'b1;
    if (a_fill_n == FW'(1)) begin
      a_min_n = in_item.seq_num;
      a_max_n = in_item.seq_num;
    end else begin
      a_min_n = (in_item.seq_num < a_min) ? in_item.seq_num : a_min;
      a_max_n = (in_item.seq_num > a_max) ? in_item.seq_num : a_max;
    end
    g_range = s_act && (ring_fill[s_idx] != '0) &&
              (in_item.seq_num >= ring_min[s_idx]) && (in_item.seq_num <= ring_max[s_idx]);
  end

  always_comb begin
    ram_we                = take && (in_item.func == FN_APPEND) && src_ok;
    ram_waddr             = AW'({s_idx, a_tail});
    ram_wdata.seq_num     = in_item.seq_num;
    ram_wdata.payload     = in_item.payload;
    ram_wdata.keys        = (int'(in_item.key_total) > MAX_KEYS) ? KEYS_W'(MAX_KEYS)
                                                                 : KEYS_W'(in_item.key_total);
    ram_wdata.stamp       = in_item.now;
    ram_raddr             = AW'({tr, ptr});
  end

  assign match = rd_v && (ram_rdata.seq_num == op_seq);

  always_comb begin
    int n;
    n = 0;
    for (int i = 0; i < SOURCES; i++) begin
      n = n + int'(ring_active[i]);
    end
    in_use = USE_W'(n);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      fin    <= 1'b0;
      total  <= '0;
      hits   <= '0;
      misses <= '0;
      for (int i = 0; i < SOURCES; i++) begin
        ring_head[i]   <= '0;
        ring_tail[i]   <= '0;
        ring_fill[i]   <= '0;
        ring_size[i]   <= '0;
        ring_min[i]    <= '0;
        ring_max[i]    <= '0;
        ring_active[i] <= 1'b0;
      end
    end else if (fin) begin
      if (res_ready) begin
        fin <= 1'b0;
      end
    end else begin
      case (state)
        ST_IDLE: begin
          if (take) begin
            found    <= 1'b0;
            evicted  <= (in_item.func == FN_APPEND) && src_ok && a_evict;
            trimmed  <= '0;
            ent      <= '0;
            op_seq   <= in_item.seq_num;
            tr       <= (in_item.func == FN_TRIM_ALL) ? '0 : s_idx;
            rd_v     <= 1'b0;
            chk      <= '0;
            all_mode <= (in_item.func == FN_TRIM_ALL);
            case (in_item.func)
              FN_APPEND: begin
                fin <= 1'b1;
                if (src_ok) begin
                  ring_active[s_idx] <= 1'b1;
                  ring_size[s_idx]   <= a_size;
                  ring_head[s_idx]   <= a_evict ? ptr_inc(a_head, a_size) : a_head;
                  ring_tail[s_idx]   <= ptr_inc(a_tail, a_size);
                  ring_fill[s_idx]   <= a_fill_n;
                  ring_min[s_idx]    <= a_min_n;
                  ring_max[s_idx]    <= a_max_n;
                  if (!a_evict) begin
                    total <= total + 1'b1;
                  end
                end
              end
              FN_GET: begin
                if (g_range) begin
                  ptr   <= ptr_dec(ring_tail[s_idx], ring_size[s_idx]);
                  state <= ST_GET;
                end else begin
                  misses <= misses + 1'b1;
                  fin    <= 1'b1;
                end
              end
              FN_TRIM_ONE: begin
                if (s_act) begin
                  state <= ST_TSEL;
                end else begin
                  fin <= 1'b1;
                end
              end
              FN_TRIM_ALL: begin
                state <= ST_TSEL;
              end
              FN_CLEAR: begin
                fin   <= 1'b1;
                total <= '0;
                for (int i = 0; i < SOURCES; i++) begin
                  ring_head[i]   <= '0;
                  ring_tail[i]   <= '0;
                  ring_fill[i]   <= '0;
                  ring_size[i]   <= '0;
                  ring_min[i]    <= '0;
                  ring_max[i]    <= '0;
                  ring_active[i] <= 1'b0;
                end
              end
              default: begin
                fin <= 1'b1;
              end
            endcase
          end
        end
        ST_GET: begin
          // One read issued per cycle, newest first; the compare works on the read data in the next cycle.
          ptr  <= ptr_dec(ptr, ring_size[tr]);
          rd_v <= 1'b1;
          chk  <= chk + FW'(rd_v);
          if (match) begin
            found <= 1'b1;
            ent   <= ram_rdata;
            hits  <= hits + 1'b1;
            state <= ST_IDLE;
            fin   <= 1'b1;
          end else if (rd_v && (chk + 1'b1 == ring_fill[tr])) begin
            misses <= misses + 1'b1;
            state  <= ST_IDLE;
            fin    <= 1'b1;
          end
        end
        ST_TSEL: begin
          rd_v <= 1'b0;
          ptr  <= ring_head[tr];
          if (ring_active[tr] && (ring_fill[tr] != '0)) begin
            state <= ST_TRIM;
          end else begin
            if (ring_active[tr]) begin
              ring_min[tr] <= '0;
              ring_max[tr] <= '0;
            end
            if (all_mode && (tr != last_src)) begin
              tr <= tr + 1'b1;
            end else begin
              state <= ST_IDLE;
              fin   <= 1'b1;
            end
          end
        end
        ST_TRIM: begin
          // Reads run ahead from the head; each checked word is the current head.
          ptr  <= ptr_inc(ptr, ring_size[tr]);
          rd_v <= 1'b1;
          if (rd_v) begin
            if (ram_rdata.seq_num < op_seq) begin
              ring_head[tr] <= ptr_inc(ring_head[tr], ring_size[tr]);
              ring_fill[tr] <= ring_fill[tr] - 1'b1;
              trimmed       <= trimmed + 1'b1;
              total         <= total - 1'b1;
              if (ring_fill[tr] == FW'(1)) begin
                ring_min[tr] <= '0;
                ring_max[tr] <= '0;
                if (all_mode && (tr != last_src)) begin
                  tr    <= tr + 1'b1;
                  state <= ST_TSEL;
                end else begin
                  state <= ST_IDLE;
                  fin   <= 1'b1;
                end
              end
            end else begin
              ring_min[tr] <= ram_rdata.seq_num;
              if (all_mode && (tr != last_src)) begin
                tr    <= tr + 1'b1;
                state <= ST_TSEL;
              end else begin
                state <= ST_IDLE;
                fin   <= 1'b1;
              end
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign res_valid      = fin;
  assign res.found      = found;
  assign res.evicted    = evicted;
  assign res.trimmed    = OUT_W'(trimmed);
  assign res.entry      = ent;
  assign res.total      = OUT_W'(total);
  assign res.hits       = hits;
  assign res.misses     = misses;
  assign res.in_use     = in_use;

  a_get_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_GET && !fin) |-> (chk < ring_fill[tr]))
    else $error("get scan ran past the ring fill");

  a_clear_total: assert property (@(posedge clk) disable iff (rst)
    (take && in_item.func == FN_CLEAR) |=> (total == '0))
    else $error("entry total not zero after clear");

  a_total_max: assert property (@(posedge clk) disable iff (rst)
    int'(total) <= SOURCES * CAPACITY)
    else $error("entry total beyond storage");

  a_trim_active: assert property (@(posedge clk) disable iff (rst)
    (state == ST_TRIM) |-> (ring_active[tr] && ring_fill[tr] != '0 && !fin))
    else $error("trim walking an empty or unused ring");

  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    fin |-> (state == ST_IDLE || state == ST_FIN_UNUSED))
    else $error("result held while the sequencer is busy");

endmodule

/* sv/gap_log_ring_table_unit.sv */
// Append, clear, no-op and out-of-range get words are finished from the idle state and
// pass their result through the output register. Get reads one slot per cycle from the
// newest entry until a match, or until every filled slot has been checked on a miss. Trim
// reads a ring holding entries from its head; trim-all visits every ring in turn.
// One word is worked on at a time; the slot memory's single read port sets the pace.
// Synchronous reset empties every ring, zeroes the counters and sets capacity to 32.
module gap_log_ring_table_unit import gltab_pkg::*; #(
  parameter int SOURCES  = 4,
  parameter int CAPACITY = 32,
  parameter int MAX_KEYS = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [CAP_W-1:0] cfg_wdata,
  input  logic             s_tvalid,
  output logic             s_tready,
  // source[1:0], seq_num[64:2], payload[96:65], key_total[104:97], now[136:105], zero fill
  input  logic [143:0]     s_tdata,
  // func[2:0]
  input  logic [2:0]       s_tuser,
  output logic             m_tvalid,
  input  logic             m_tready,
  // trimmed[7:0], entry_seq[70:8], entry_payload[102:71], entry_keys[107:103],
  // entry_time[139:108], entry_count[147:140], hits[179:148], misses[211:180],
  // sources_in_use[214:212], zero fill
  output logic [215:0]     m_tdata,
  // found[0], evicted[1]
  output logic [1:0]       m_tuser
);

  // The capacity register is only sampled when a ring is first created.
  logic [CAP_W-1:0] capacity;
  item_t            item;
  logic             res_valid;
  logic             res_ready;
  result_t          res;
  result_t          out_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (cfg_we) begin
      capacity <= cfg_wdata;
    end
  end

  always_comb begin
    item.func      = s_tuser;
    item.source    = s_tdata[1:0];
    item.seq_num   = s_tdata[64:2];
    item.payload   = s_tdata[96:65];
    item.key_total = s_tdata[104:97];
    item.now       = s_tdata[136:105];
  end

  gltab_seq #(
    .SOURCES  (SOURCES),
    .CAPACITY (CAPACITY),
    .MAX_KEYS (MAX_KEYS)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .capacity  (capacity),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_item   (item),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // Output register: the sequencer hands over its result as soon as this stage is free,
  // so it can take the next word while the previous result still waits downstream.
  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_res <= res;
    end
  end

  assign m_tuser = {out_res.evicted, out_res.found};
  assign m_tdata = {1'b0, out_res.in_use, out_res.misses, out_res.hits, out_res.total,
                    out_res.entry.stamp, out_res.entry.keys, out_res.entry.payload,
                    out_res.entry.seq_num, out_res.trimmed};

endmodule
